// ----- hdl/sbfr_pkg.sv -----
package sbfr_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int PAYLOAD_LEN = FRAME_BYTES - 1;
  localparam int IDX_W = 6;
  localparam int COUNT_W = $clog2(FRAME_BYTES + 1);
  localparam int STORE_AW = IDX_W + 1;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int CNT_W = 32;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FAIL = 1'b1;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic             fail;
    logic             bank;
    logic [CNT_W-1:0] good_count;
    logic [CNT_W-1:0] bad_count;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_of_run;
    logic [CNT_W-1:0] good_count;
    logic [CNT_W-1:0] bad_count;
  } result_t;

endpackage

// ----- hdl/sbfr_frame_store.sv -----
module sbfr_frame_store (
  input  logic                          clk,
  input  sbfr_pkg::wr_t                 wr,
  input  logic                          rd_en,
  input  logic [sbfr_pkg::STORE_AW-1:0] rd_addr,
  output logic [7:0]                    rd_data
);
  import sbfr_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/sbfr_cmd_fifo.sv -----
module sbfr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbfr_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output sbfr_pkg::cmd_t dout,
  output logic           empty
);
  import sbfr_pkg::*;

  cmd_t entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr;
  logic [CMDQ_AW-1:0] rptr;
  logic [CMDQ_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty = (count == '0);
  assign dout = entries[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= din;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/sbfr_front.sv -----
module sbfr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [7:0]     cfg_data,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     rx_byte,
  output sbfr_pkg::wr_t  wr,
  input  sbfr_pkg::rel_t rel,
  output logic           cmd_push,
  output sbfr_pkg::cmd_t cmd,
  input  logic           cmd_full
);
  import sbfr_pkg::*;

  logic [7:0]         start_byte;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;
  logic [CNT_W-1:0]   good_frames;
  logic [CNT_W-1:0]   bad_frames;
  logic               bank;
  logic [1:0]         busy;

  logic               in_payload;
  logic               at_check;
  logic               accept;
  logic               good;
  logic [COUNT_W-1:0] slot;

  assign in_payload = (byte_count != '0) && (byte_count < COUNT_W'(FRAME_BYTES));
  assign at_check = (byte_count == COUNT_W'(FRAME_BYTES));
  assign full = (in_payload && busy[bank]) || (at_check && cmd_full);
  assign accept = push && !full;
  assign good = (rx_byte == running_sum);
  assign slot = byte_count - COUNT_W'(1);

  assign wr.en = accept && in_payload;
  assign wr.addr = {bank, slot[IDX_W-1:0]};
  assign wr.data = rx_byte;

  assign cmd_push = accept && at_check;
  assign cmd.fail = !good;
  assign cmd.bank = bank;
  assign cmd.good_count = good ? good_frames + 1'b1 : good_frames;
  assign cmd.bad_count = good ? bad_frames : bad_frames + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
      byte_count <= '0;
      running_sum <= '0;
      good_frames <= '0;
      bad_frames <= '0;
      bank <= 1'b0;
      busy <= '0;
    end else begin
      if (cfg_write) begin
        start_byte <= cfg_data;
      end
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
      if (accept) begin
        if (byte_count == '0) begin
          if (rx_byte == start_byte) begin
            byte_count <= COUNT_W'(1);
            running_sum <= '0;
          end
        end else if (in_payload) begin
          running_sum <= running_sum + rx_byte;
          byte_count <= byte_count + 1'b1;
        end else begin
          byte_count <= '0;
          running_sum <= '0;
          good_frames <= cmd.good_count;
          bad_frames <= cmd.bad_count;
          if (good) begin
            busy[bank] <= 1'b1;
            bank <= !bank;
          end
        end
      end
    end
  end

endmodule

// ----- hdl/sbfr_back.sv -----
module sbfr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sbfr_pkg::cmd_t                cmd,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  output logic                          rd_en,
  output logic [sbfr_pkg::STORE_AW-1:0] rd_addr,
  input  logic [7:0]                    rd_data,
  output sbfr_pkg::rel_t                rel,
  output logic                          empty,
  input  logic                          pop,
  output sbfr_pkg::result_t             res
);
  import sbfr_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

  state_t           state;
  cmd_t             cur;
  logic [IDX_W-1:0] rd_idx;
  logic             inflight;
  logic [IDX_W-1:0] inflight_idx;
  logic             inflight_last;

  result_t            outq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] owptr;
  logic [OUTQ_AW-1:0] orptr;
  logic [OUTQ_AW:0]   ocount;

  logic    room;
  logic    can_issue;
  logic    fail_push;
  logic    owr;
  logic    opop;
  result_t owr_data;

  assign room = (({1'b0, ocount} + (OUTQ_AW + 2)'(inflight)) < (OUTQ_AW + 2)'(OUTQ_DEPTH));
  assign can_issue = (state == ST_EMIT) && room;
  assign fail_push = (state == ST_IDLE) && !cmd_empty && cmd.fail && !inflight
                     && (ocount < (OUTQ_AW + 1)'(OUTQ_DEPTH));
  assign cmd_pop = (state == ST_IDLE) && !cmd_empty && (!cmd.fail || fail_push);

  assign rd_en = can_issue;
  assign rd_addr = {cur.bank, rd_idx};
  assign rel.valid = can_issue && (rd_idx == LAST_IDX);
  assign rel.bank = cur.bank;

  assign owr = inflight || fail_push;
  assign opop = pop && !empty;
  assign empty = (ocount == '0);
  assign res = outq[orptr];

  always_comb begin
    if (inflight) begin
      owr_data.kind = KIND_PAYLOAD;
      owr_data.payload_byte = rd_data;
      owr_data.byte_index = inflight_idx;
      owr_data.last_of_run = inflight_last;
      owr_data.good_count = cur.good_count;
      owr_data.bad_count = cur.bad_count;
    end else begin
      owr_data.kind = KIND_FAIL;
      owr_data.payload_byte = '0;
      owr_data.byte_index = '0;
      owr_data.last_of_run = 1'b1;
      owr_data.good_count = cmd.good_count;
      owr_data.bad_count = cmd.bad_count;
    end
  end

  always_ff @(posedge clk) begin
    if (owr) begin
      outq[owptr] <= owr_data;
    end
    inflight_idx <= rd_idx;
    inflight_last <= (rd_idx == LAST_IDX);
    if (rst) begin
      state <= ST_IDLE;
      inflight <= 1'b0;
      rd_idx <= '0;
      owptr <= '0;
      orptr <= '0;
      ocount <= '0;
    end else begin
      inflight <= can_issue;
      case (state)
        ST_IDLE: begin
          if (cmd_pop && !cmd.fail) begin
            cur <= cmd;
            rd_idx <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_issue) begin
            rd_idx <= rd_idx + 1'b1;
            if (rd_idx == LAST_IDX) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (owr) begin
        owptr <= owptr + 1'b1;
      end
      if (opop) begin
        orptr <= orptr + 1'b1;
      end
      case ({owr, opop})
        2'b10: ocount <= ocount + 1'b1;
        2'b01: ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

endmodule

// ----- hdl/start_byte_frame_receiver_core.sv -----
// Receives a framed byte stream: while idle, bytes are dropped until one matches the start
// byte register; the next 63 bytes are payload and the byte after them is a checksum that
// must equal the 8-bit wrapping sum of the payload. A good frame yields its 63 payload bytes
// in order, the final one marked last_of_run; a bad frame yields one failure word. Both
// frame counters carried on every word are the values after that frame. The front end takes
// one byte per cycle while nothing holds it off. The checksum byte is taken when the
// two-entry command queue has room, and a payload byte is held off while the store bank it
// would fill still awaits emission; the store has two banks, so one frame can arrive while
// the previous one drains. A good frame drains through the single read port of the frame
// store, and a read is started only while the two-entry output queue, counting the read in
// flight, has room, so even with pop held high the drain pauses while that queue is full. A
// frame is 65 bytes on the input, and back-to-back good frames are paced by the drain. No
// clearing pass is needed after reset.
module start_byte_frame_receiver_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [7:0]                       cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       rx_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic                             kind,
  output logic [7:0]                       payload_byte,
  output logic [sbfr_pkg::IDX_W-1:0]       byte_index,
  output logic                             last_of_run,
  output logic [sbfr_pkg::CNT_W-1:0]       good_frame_count,
  output logic [sbfr_pkg::CNT_W-1:0]       bad_frame_count
);
  import sbfr_pkg::*;

  wr_t                 wr;
  rel_t                rel;
  cmd_t                cmd_in;
  cmd_t                cmd_out;
  logic                cmd_push;
  logic                cmd_full;
  logic                cmd_pop;
  logic                cmd_empty;
  logic                rd_en;
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;
  result_t             res;

  sbfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .wr        (wr),
    .rel       (rel),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  sbfr_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  sbfr_frame_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rel       (rel),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign kind = res.kind;
  assign payload_byte = res.payload_byte;
  assign byte_index = res.byte_index;
  assign last_of_run = res.last_of_run;
  assign good_frame_count = res.good_count;
  assign bad_frame_count = res.bad_count;

endmodule

// ----- sim/start_byte_frame_receiver_core_tb.sv -----
module start_byte_frame_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfr_pkg::*;

  localparam int IDLE_PCT = 15;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_GAP = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic pop = 1'b0;

  wire full;
  wire empty;
  wire kind;
  wire [7:0] payload_byte;
  wire [IDX_W-1:0] byte_index;
  wire last_of_run;
  wire [CNT_W-1:0] good_frame_count;
  wire [CNT_W-1:0] bad_frame_count;

  // Receiver state as the testbench expects it to be.
  logic [7:0] start_reg = 8'h00;
  logic [6:0] rx_count = 7'd0;
  logic [7:0] frame_bytes [FRAME_BYTES];
  logic [7:0] payload_sum = 8'h00;
  logic [CNT_W-1:0] good_frames_seen = '0;
  logic [CNT_W-1:0] bad_frames_seen = '0;
  result_t pending_words[$];

  logic [7:0] frame_buf [PAYLOAD_LEN];
  bit steady = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int good_sent = 0;
  int bad_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;

  start_byte_frame_receiver_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .payload_byte(payload_byte),
    .byte_index(byte_index),
    .last_of_run(last_of_run),
    .good_frame_count(good_frame_count),
    .bad_frame_count(bad_frame_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void predict_frame_byte(input logic [7:0] b);
    result_t w;
    if (rx_count == 7'd0) begin
      if (b == start_reg) begin
        rx_count = 7'd1;
        payload_sum = 8'h00;
      end
    end else if (rx_count < FRAME_BYTES) begin
      frame_bytes[6'(rx_count - 7'd1)] = b;
      payload_sum = payload_sum + b;
      rx_count = rx_count + 7'd1;
    end else begin
      rx_count = 7'd0;
      if (b == payload_sum) begin
        good_frames_seen = good_frames_seen + 1;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
          w.kind = KIND_PAYLOAD;
          w.payload_byte = frame_bytes[i];
          w.byte_index = IDX_W'(i);
          w.last_of_run = (i == PAYLOAD_LEN - 1);
          w.good_count = good_frames_seen;
          w.bad_count = bad_frames_seen;
          pending_words.push_back(w);
        end
      end else begin
        bad_frames_seen = bad_frames_seen + 1;
        w.kind = KIND_FAIL;
        w.payload_byte = 8'h00;
        w.byte_index = '0;
        w.last_of_run = 1'b1;
        w.good_count = good_frames_seen;
        w.bad_count = bad_frames_seen;
        pending_words.push_back(w);
      end
      payload_sum = 8'h00;
    end
  endfunction

  task automatic send_rx(input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_frame_byte(b);
    bytes_sent++;
  endtask

  task automatic drain_pipeline();
    push <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    drain_pipeline();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    start_reg = v;
    settings_used++;
  endtask

  // Sends the start byte, the payload held in frame_buf and a checksum that is off by
  // sum_offset, so an offset of zero gives a good frame.
  task automatic send_frame(input logic [7:0] sum_offset);
    logic [7:0] sum;
    sum = 8'h00;
    send_rx(start_reg);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      send_rx(frame_buf[i]);
      sum = sum + frame_buf[i];
    end
    send_rx(sum + sum_offset);
    if (sum_offset == 8'h00) good_sent++;
    else bad_sent++;
  endtask

  function automatic logic [7:0] random_non_start();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == start_reg);
    return b;
  endfunction

  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_checked++;
        if (pending_words.size() == 0) begin
          $error("unexpected word: kind %0d payload_byte %0h byte_index %0d", kind,
                 payload_byte, byte_index);
          errors++;
        end else begin
          w = pending_words.pop_front();
          if (kind !== w.kind) begin
            $error("kind: expected %0d, actual %0d", w.kind, kind);
            errors++;
          end
          if (payload_byte !== w.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", w.payload_byte, payload_byte);
            errors++;
          end
          if (byte_index !== w.byte_index) begin
            $error("byte_index: expected %0d, actual %0d", w.byte_index, byte_index);
            errors++;
          end
          if (last_of_run !== w.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", w.last_of_run, last_of_run);
            errors++;
          end
          if (good_frame_count !== w.good_count) begin
            $error("good_frame_count: expected %0d, actual %0d", w.good_count,
                   good_frame_count);
            errors++;
          end
          if (bad_frame_count !== w.bad_count) begin
            $error("bad_frame_count: expected %0d, actual %0d", w.bad_count,
                   bad_frame_count);
            errors++;
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("start_byte_frame_receiver_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Bytes other than the start byte are dropped while the receiver is hunting.
  task automatic test_idle_bytes_ignored();
    send_rx(8'hFF);
    send_rx(8'h80);
    send_rx(8'h01);
    send_rx(8'h7F);
  endtask

  // The start byte inside a frame is ordinary data and must not restart it.
  task automatic test_good_frame_with_start_bytes();
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (i % 3)
        0: begin
          frame_buf[i] = start_reg;
        end
        1: begin
          frame_buf[i] = 8'hFF;
        end
        default: begin
          frame_buf[i] = 8'(i * 4 + 1);
        end
      endcase
    end
    send_frame(8'h00);
  endtask

  task automatic test_bad_checksum();
    for (int i = 0; i < PAYLOAD_LEN; i++) frame_buf[i] = 8'hFF;
    send_frame(8'h01);
    send_rx(random_non_start());
  endtask

  task automatic test_start_byte_extremes();
    write_start_byte(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFE);
    for (int i = 0; i < PAYLOAD_LEN; i++) frame_buf[i] = (i % 2 == 0) ? 8'hFF : 8'h00;
    send_frame(8'h00);
  endtask

  // Mostly well-formed frames with random content; the rest is noise, corrupted
  // checksums and runs of random bytes that may open a frame out of step.
  task automatic test_random_traffic();
    int phase_start;
    write_start_byte(8'($urandom_range(1, 254)));
    steady = 1'b1;
    phase_start = bytes_sent;
    while (bytes_sent - phase_start < 60) begin
      while (rx_count != 7'd0) send_rx(8'($urandom_range(255)));
      repeat ($urandom_range(3)) send_rx(random_non_start());
      if ($urandom_range(99) < 85) begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
          frame_buf[i] = ($urandom_range(9) == 0) ? start_reg : 8'($urandom_range(255));
        end
        send_frame(($urandom_range(99) < 75) ? 8'h00 : 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 20)) send_rx(8'($urandom_range(255)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes_ignored();
    test_good_frame_with_start_bytes();
    test_bad_checksum();
    test_start_byte_extremes();
    test_random_traffic();
    drain_pipeline();
    $display("%0d bytes sent under %0d start byte settings; %0d good and %0d corrupted frames",
             bytes_sent, settings_used, good_sent, bad_sent);
    $display("%0d result words checked, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("start_byte_frame_receiver_core_tb: PASS");
    end else begin
      $display("start_byte_frame_receiver_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sbfr_pkg.sv
hdl/sbfr_frame_store.sv
hdl/sbfr_cmd_fifo.sv
hdl/sbfr_front.sv
hdl/sbfr_back.sv
hdl/start_byte_frame_receiver_core.sv
sim/start_byte_frame_receiver_core_tb.sv
